FILE: sv/rbca_pkg.sv
// ----------------------------------------------------------------------------
// rbca_pkg: shared types and constants for the reorder buffer ack unit
// Field widths, result codes and back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package rbca_pkg;

    localparam int SEQ_W = 31;
    localparam int LEN_W = 11;
    localparam int HND_W = 6;
    localparam int KIND_W = 2;
    // width used for length saturation and handle reduction compares
    localparam int CMP_W = 17;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic             is_end;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [HND_W-1:0] hnd;
    } t_seg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EOS,
        S_PURGE,
        S_CLASS,
        S_DSEARCH,
        S_DADV,
        S_EMIT_RD,
        S_EMIT_LD,
        S_ACK
    } t_state;

endpackage
`default_nettype wire

FILE: sv/reorder_buffer_cumulative_ack_unit.sv
// ----------------------------------------------------------------------------
// reorder_buffer_cumulative_ack_unit: receive reassembly with cumulative ack
// Usage:
//   Input channel (i_valid/o_ready) carries one segment header per transfer:
//   sequence number, length (zero = end of stream) and payload handle.
//   Output channel (o_valid/i_ready) carries result transfers: write
//   commands for in-order payload, then one cumulative ack; an end-of-stream
//   segment yields a single end result. o_last_result marks a segment's
//   final result; o_ack_number is the expected byte after the whole segment.
//   A 2-deep intake queue accepts segments while the back end works.
// Sequence:
//   Back end runs a stale purge and a classify step per segment, then for
//   each drained table entry a search and then a slot read, then for each
//   write a buffer read and an output load, and last the ack. The drain
//   searches the table sequentially, one entry per search step.
// Reset: table emptied, expected byte set to 0, queues and output cleared.
// Stall: results stay in the output register while i_ready is low; the
//   back end waits and the intake queue fills, then drops o_ready.
// ----------------------------------------------------------------------------
`default_nettype none
module reorder_buffer_cumulative_ack_unit #(
    parameter int TABLE_SLOTS  = 16,
    parameter int MAX_SEGMENT  = 1024,
    parameter int HANDLE_COUNT = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [rbca_pkg::SEQ_W-1:0]  i_seq_number,
    input  wire logic [rbca_pkg::LEN_W-1:0]  i_seg_length,
    input  wire logic [rbca_pkg::HND_W-1:0]  i_payload_handle,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rbca_pkg::KIND_W-1:0]      o_result_kind,
    output logic [rbca_pkg::SEQ_W-1:0]       o_write_offset,
    output logic [rbca_pkg::LEN_W-1:0]       o_write_length,
    output logic [rbca_pkg::HND_W-1:0]       o_write_handle,
    output logic [rbca_pkg::SEQ_W-1:0]       o_ack_number,
    output logic                             o_dropped,
    output logic                             o_last_result
);
    import rbca_pkg::*;

    // front to back segment transfer
    t_seg w_seg;
    logic w_seg_valid;
    logic w_seg_ready;

    // intake: length saturation, handle reduction, queue
    rbca_front #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .HANDLE_COUNT(HANDLE_COUNT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_seq_number    (i_seq_number),
        .i_seg_length    (i_seg_length),
        .i_payload_handle(i_payload_handle),
        .o_seg_valid     (w_seg_valid),
        .i_seg_ready     (w_seg_ready),
        .o_seg           (w_seg)
    );

    // table, drain and result output
    rbca_back #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seg_valid   (w_seg_valid),
        .o_seg_ready   (w_seg_ready),
        .i_seg         (w_seg),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_write_offset(o_write_offset),
        .o_write_length(o_write_length),
        .o_write_handle(o_write_handle),
        .o_ack_number  (o_ack_number),
        .o_dropped     (o_dropped),
        .o_last_result (o_last_result)
    );

endmodule
`default_nettype wire

FILE: sv/rbca_front.sv
// ----------------------------------------------------------------------------
// rbca_front: segment intake
// Normalizes length and handle, queues segments for the back end (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none
module rbca_front #(
    parameter int MAX_SEGMENT  = 1024,
    parameter int HANDLE_COUNT = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [rbca_pkg::SEQ_W-1:0] i_seq_number,
    input  wire logic [rbca_pkg::LEN_W-1:0] i_seg_length,
    input  wire logic [rbca_pkg::HND_W-1:0] i_payload_handle,
    output logic                            o_seg_valid,
    input  wire logic                       i_seg_ready,
    output rbca_pkg::t_seg                  o_seg
);
    import rbca_pkg::*;

    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_SEGMENT);
    localparam logic [CMP_W-1:0] HCOUNT  = CMP_W'(HANDLE_COUNT);

    // restoring reduction, one compare-subtract per handle bit
    function automatic logic [HND_W-1:0] hnd_mod(input logic [HND_W-1:0] h);
        logic [CMP_W-1:0] v;
        logic [CMP_W-1:0] d;
        v = CMP_W'(h);
        for (int s = HND_W - 1; s >= 0; s--) begin
            d = HCOUNT << s;
            if (v >= d) begin
                v = v - d;
            end
        end
        return v[HND_W-1:0];
    endfunction

    t_seg       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_seg       w_in;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_in.is_end = (i_seg_length == '0);
        w_in.seq    = i_seq_number;
        w_in.len    = (CMP_W'(i_seg_length) > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : i_seg_length;
        w_in.hnd    = hnd_mod(i_payload_handle);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_seg_valid = (r_cnt != 2'd0);
    assign w_pop       = o_seg_valid && i_seg_ready;
    assign o_seg       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

FILE: sv/rbca_back.sv
// ----------------------------------------------------------------------------
// rbca_back: reassembly table, drain sequencer and result output
// Stores ahead segments, drains in-order runs, emits writes then the ack.
// ----------------------------------------------------------------------------
`default_nettype none
module rbca_back #(
    parameter int TABLE_SLOTS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_seg_valid,
    output logic                             o_seg_ready,
    input  wire rbca_pkg::t_seg              i_seg,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rbca_pkg::KIND_W-1:0]      o_result_kind,
    output logic [rbca_pkg::SEQ_W-1:0]       o_write_offset,
    output logic [rbca_pkg::LEN_W-1:0]       o_write_length,
    output logic [rbca_pkg::HND_W-1:0]       o_write_handle,
    output logic [rbca_pkg::SEQ_W-1:0]       o_ack_number,
    output logic                             o_dropped,
    output logic                             o_last_result
);
    import rbca_pkg::*;

    localparam int SIW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW  = $clog2(TABLE_SLOTS + 1);

    t_state r_state;
    t_state n_state;
    t_seg   r_item;
    logic [SEQ_W-1:0]       r_next;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [SEQ_W-1:0]       r_seq [TABLE_SLOTS];

    // slot payload store
    logic [LEN_W-1:0] m_len [TABLE_SLOTS];
    logic [HND_W-1:0] m_hnd [TABLE_SLOTS];
    logic [LEN_W-1:0] r_m_len;
    logic [HND_W-1:0] r_m_hnd;

    // pending write commands for the current step
    logic [SEQ_W-1:0] b_off [TABLE_SLOTS];
    logic [LEN_W-1:0] b_len [TABLE_SLOTS];
    logic [HND_W-1:0] b_hnd [TABLE_SLOTS];
    logic [SEQ_W-1:0] r_b_off;
    logic [LEN_W-1:0] r_b_len;
    logic [HND_W-1:0] r_b_hnd;
    logic [CW-1:0]    r_cnt;
    logic [SIW-1:0]   r_idx;
    logic             r_drop;

    logic [KIND_W-1:0] r_o_kind;
    logic [SEQ_W-1:0]  r_o_off;
    logic [LEN_W-1:0]  r_o_len;
    logic [HND_W-1:0]  r_o_hnd;
    logic [SEQ_W-1:0]  r_o_ack;
    logic              r_o_drop;
    logic              r_o_last;
    logic              r_o_valid;

    logic             w_match_hit;
    logic [SIW-1:0]   w_match_idx;
    logic             w_free_hit;
    logic [SIW-1:0]   w_free_idx;
    logic             w_dup;
    logic             w_ahead;
    logic             w_equal;
    logic             w_out_free;
    logic             w_last_wr;
    logic             w_ld;
    logic [KIND_W-1:0] w_kind;
    logic [SEQ_W-1:0] w_off;
    logic [LEN_W-1:0] w_len;
    logic [HND_W-1:0] w_hnd;
    logic             w_drop;
    logic             w_last;

    // lowest matching / free slot
    always_comb begin
        w_match_hit = 1'b0;
        w_match_idx = '0;
        w_free_hit  = 1'b0;
        w_free_idx  = '0;
        w_dup       = 1'b0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_seq[i] == r_next) begin
                w_match_hit = 1'b1;
                w_match_idx = SIW'(i);
            end
            if (!r_valid[i]) begin
                w_free_hit = 1'b1;
                w_free_idx = SIW'(i);
            end
            if (r_valid[i] && r_seq[i] == r_item.seq) begin
                w_dup = 1'b1;
            end
        end
    end

    assign w_ahead    = r_item.seq > r_next;
    assign w_equal    = r_item.seq == r_next;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_last_wr  = (CW'(r_idx) + CW'(1)) == r_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_seg_valid) begin
                    n_state = i_seg.is_end ? S_EOS : S_PURGE;
                end
            end
            S_PURGE:   n_state = S_CLASS;
            S_CLASS:   n_state = (w_equal && w_free_hit) ? S_DSEARCH : S_ACK;
            S_DSEARCH: n_state = w_match_hit ? S_DADV : S_EMIT_RD;
            S_DADV:    n_state = S_DSEARCH;
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (w_out_free) begin
                    n_state = w_last_wr ? S_ACK : S_EMIT_RD;
                end
            end
            S_ACK, S_EOS: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result selection
    always_comb begin
        w_ld   = 1'b0;
        w_kind = KIND_ACK;
        w_off  = '0;
        w_len  = '0;
        w_hnd  = '0;
        w_drop = 1'b0;
        w_last = 1'b0;
        unique case (r_state)
            S_EOS: begin
                w_ld   = w_out_free;
                w_kind = KIND_END;
                w_last = 1'b1;
            end
            S_EMIT_LD: begin
                w_ld   = w_out_free;
                w_kind = KIND_WRITE;
                w_off  = r_b_off;
                w_len  = r_b_len;
                w_hnd  = r_b_hnd;
            end
            S_ACK: begin
                w_ld   = w_out_free;
                w_kind = KIND_ACK;
                w_drop = r_drop;
                w_last = 1'b1;
            end
            default: begin
                w_ld = 1'b0;
            end
        endcase
    end

    assign o_seg_ready = (r_state == S_IDLE);

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLASS && w_ahead && !w_dup && w_free_hit) begin
            m_len[w_free_idx] <= r_item.len;
            m_hnd[w_free_idx] <= r_item.hnd;
        end
        r_m_len <= m_len[w_match_idx];
        r_m_hnd <= m_hnd[w_match_idx];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLASS) begin
            b_off[0] <= r_item.seq;
            b_len[0] <= r_item.len;
            b_hnd[0] <= r_item.hnd;
        end else if (r_state == S_DADV) begin
            b_off[r_cnt[SIW-1:0]] <= r_next;
            b_len[r_cnt[SIW-1:0]] <= r_m_len;
            b_hnd[r_cnt[SIW-1:0]] <= r_m_hnd;
        end
        r_b_off <= b_off[r_idx];
        r_b_len <= b_len[r_idx];
        r_b_hnd <= b_hnd[r_idx];
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_seg_valid) begin
            r_item <= i_seg;
        end
        if (r_state == S_CLASS && w_ahead && !w_dup && w_free_hit) begin
            r_seq[w_free_idx] <= r_item.seq;
        end
        if (w_ld) begin
            r_o_kind <= w_kind;
            r_o_off  <= w_off;
            r_o_len  <= w_len;
            r_o_hnd  <= w_hnd;
            r_o_ack  <= r_next;
            r_o_drop <= w_drop;
            r_o_last <= w_last;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next    <= '0;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ld) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_PURGE: begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (r_seq[i] < r_next) begin
                            r_valid[i] <= 1'b0;
                        end
                    end
                end
                S_CLASS: begin
                    r_idx  <= '0;
                    r_cnt  <= '0;
                    r_drop <= !w_free_hit && (w_equal || (w_ahead && !w_dup));
                    if (w_ahead && !w_dup && w_free_hit) begin
                        r_valid[w_free_idx] <= 1'b1;
                    end
                    if (w_equal && w_free_hit) begin
                        r_cnt  <= CW'(1);
                        r_next <= r_next + SEQ_W'(r_item.len);
                    end
                end
                S_DSEARCH: begin
                    if (w_match_hit) begin
                        r_valid[w_match_idx] <= 1'b0;
                    end
                end
                S_DADV: begin
                    r_cnt  <= r_cnt + CW'(1);
                    r_next <= r_next + SEQ_W'(r_m_len);
                end
                S_EMIT_LD: begin
                    if (w_out_free) begin
                        r_idx <= r_idx + SIW'(1);
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_kind  = r_o_kind;
    assign o_write_offset = r_o_off;
    assign o_write_length = r_o_len;
    assign o_write_handle = r_o_hnd;
    assign o_ack_number   = r_o_ack;
    assign o_dropped      = r_o_drop;
    assign o_last_result  = r_o_last;

    a_drop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == KIND_WRITE) |-> !r_o_drop)
        else $error("write result carries drop flag");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == KIND_END) |-> r_o_last)
        else $error("end result not marked last");

    a_drain_has_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSEARCH) |-> (r_cnt != '0))
        else $error("drain without the leading write");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_SLOTS))
        else $error("write count beyond table size");

endmodule
`default_nettype wire
